/* design/seven_bit_packet_deframer_assert.svh */
// assertion macros shared by the deframer rtl
`ifndef SEVEN_BIT_PACKET_DEFRAMER_ASSERT_SVH
`define SEVEN_BIT_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define SBPD_ASSERT_NOW(lbl, clock, rstn, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("sbpd same-cycle check failed");

// next-cycle implication
`define SBPD_ASSERT_NEXT(lbl, clock, rstn, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("sbpd next-cycle check failed");

`endif

/* design/sbpd_pkg.sv */
// types, constants and helpers for the seven-bit packet deframer
`timescale 1ns / 1ps

package sbpd_pkg;

	// largest packet in payload bytes
	localparam int MAX_PACKET_LENGTH = 256;

	// reported length width and its saturation value
	localparam int LEN_W   = 9;
	localparam int LEN_MAX = (1 << LEN_W) - 1;

	// byte counter wide enough for the maximum and for the reported length
	localparam int CNT_RAW = $clog2(MAX_PACKET_LENGTH + 1);
	localparam int CNT_W   = (CNT_RAW > LEN_W) ? CNT_RAW : LEN_W;

	// fill state: bits already gathered, aligned means nothing pending
	localparam int          FILL_W       = 4;
	localparam logic [FILL_W-1:0] FILL_ALIGNED = 4'd8;
	localparam logic [FILL_W-1:0] FILL_START   = 4'd6;
	localparam logic [FILL_W-1:0] FILL_DATA    = 4'd7;

	// line byte kinds by their top bits
	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_START,
		KIND_END
	} kind_t;

	// deframer state carried from item to item
	typedef struct packed {
		logic [7:0]        partial_byte;
		logic [FILL_W-1:0] fill_bits;
		logic [CNT_W-1:0]  byte_count;
		logic              overflowed;
	} state_t;

	// one result item
	typedef struct packed {
		logic [7:0]       out_byte;
		logic             has_byte;
		logic             packet_end;
		logic [LEN_W-1:0] packet_length;
		logic             overflow;
	} result_t;

	// decode the top bits of a line byte
	function automatic kind_t classify(input logic [7:0] b);
		kind_t k;
		case (b[7:6])
			2'b10:   k = KIND_START;
			2'b11:   k = KIND_END;
			default: k = KIND_DATA;
		endcase
		return k;
	endfunction

endpackage

/* design/seven_bit_packet_deframer.sv */
// top level of the seven-bit packet deframer
//
// Input channel: one received line byte per item on rx_byte, handshake
// in_valid / in_stall. Top bits 10 open a packet (six payload bits), top
// bit 0 carries seven bits, top bits 11 close the packet (up to six bits).
// Output channel: out_valid / out_stall with out_byte, has_byte,
// packet_end, packet_length and overflow. A data byte gives a result only
// when it completes a payload byte that fits in the packet; an end byte
// always gives one result carrying the packet length.
// Path: an accepted item is held in the input register, then its result
// goes into the result register fed by the unpack logic.
// Throughput: one item per cycle while in_stall is low; the unpack logic and
// the state update sit in a single stage between the input and result registers.
// Items that give no result move on even while the output is stalled.
// Reset: state returns to aligned with zero count, both registers empty.
// Stall: a held result keeps its fields; an item that would give a new
// result waits in the input register, which then stalls the input side.
`timescale 1ns / 1ps

`include "seven_bit_packet_deframer_assert.svh"

module seven_bit_packet_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 rx_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic                       has_byte,
	output logic                       packet_end,
	output logic [sbpd_pkg::LEN_W-1:0] packet_length,
	output logic                       overflow
);

	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	sbpd_pkg::state_t  state_q;
	sbpd_pkg::state_t  state_nxt;
	sbpd_pkg::result_t step_res;
	logic              step_valid;
	logic              adv;
	logic              out_valid_q;
	sbpd_pkg::result_t out_q;

	// unpack logic for the item in the input register
	sbpd_unpack u_unpack (
		.rx_byte   (rx_byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (step_res),
		.res_valid (step_valid)
	);

	// the item moves on unless it has a result and the output is full and held
	assign adv      = valid_s1 && (!step_valid || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.partial_byte <= 8'h00;
			state_q.fill_bits    <= sbpd_pkg::FILL_ALIGNED;
			state_q.byte_count   <= '0;
			state_q.overflowed   <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && step_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step_valid) begin
			out_q <= step_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_q.out_byte;
	assign has_byte      = out_q.has_byte;
	assign packet_end    = out_q.packet_end;
	assign packet_length = out_q.packet_length;
	assign overflow      = out_q.overflow;

	// checks on the deframer logic
	`SBPD_ASSERT_NOW(a_fill_range, clk, arst_n, 1'b1, (state_q.fill_bits != '0) && (state_q.fill_bits <= sbpd_pkg::FILL_ALIGNED))
	`SBPD_ASSERT_NOW(a_data_has_byte, clk, arst_n, out_valid && !packet_end, has_byte)
	`SBPD_ASSERT_NOW(a_byte_counted, clk, arst_n, out_valid && has_byte, packet_length != '0)
	`SBPD_ASSERT_NEXT(a_end_clears, clk, arst_n, adv && step_valid && step_res.packet_end, (state_q.byte_count == '0) && (state_q.fill_bits == sbpd_pkg::FILL_ALIGNED))

endmodule

/* design/sbpd_unpack.sv */
// next-state and result logic for one line byte
`timescale 1ns / 1ps

module sbpd_unpack (
	input  logic [7:0]      rx_byte,
	input  sbpd_pkg::state_t cur,
	output sbpd_pkg::state_t nxt,
	output sbpd_pkg::result_t res,
	output logic            res_valid
);

	logic [sbpd_pkg::FILL_W-1:0] fill_eff;
	logic [2:0]                  fill_m1;
	logic [15:0]                 data_shift;
	logic [7:0]                  data_val;
	logic [7:0]                  end_val;
	logic                        done;
	logic                        room;
	logic [7:0]                  val;
	logic [sbpd_pkg::CNT_W-1:0]  count_new;
	logic                        ovf_new;
	logic                        accepted;
	sbpd_pkg::kind_t             kind;

	// out-of-range fill counts as aligned
	assign fill_eff = (cur.fill_bits == '0 || cur.fill_bits > sbpd_pkg::FILL_ALIGNED)
		? sbpd_pkg::FILL_ALIGNED : cur.fill_bits;
	assign fill_m1  = 3'(fill_eff - 4'd1);
	assign kind     = sbpd_pkg::classify(rx_byte);

	// data byte: seven bits split across the current and next payload byte
	assign data_shift = {rx_byte, 8'h00} >> fill_m1;
	assign data_val   = cur.partial_byte | 8'({1'b0, rx_byte[6:0]} >> fill_m1);

	// end byte: six trailing bits below the filled ones
	assign end_val = cur.partial_byte | 8'({rx_byte[5:0], 2'b00} >> fill_eff);

	// completion, length limit and byte counting
	assign done = (kind == sbpd_pkg::KIND_END) ? (fill_eff != sbpd_pkg::FILL_ALIGNED)
		: ((kind == sbpd_pkg::KIND_DATA) && (fill_eff != sbpd_pkg::FILL_ALIGNED));
	assign room      = cur.byte_count < sbpd_pkg::CNT_W'(sbpd_pkg::MAX_PACKET_LENGTH);
	assign accepted  = done && room;
	assign ovf_new   = cur.overflowed || (done && !room);
	assign count_new = accepted ? cur.byte_count + sbpd_pkg::CNT_W'(1) : cur.byte_count;
	assign val       = (kind == sbpd_pkg::KIND_END) ? end_val : data_val;

	// result fields
	always_comb begin
		res.out_byte      = accepted ? val : 8'h00;
		res.has_byte      = accepted;
		res.packet_end    = (kind == sbpd_pkg::KIND_END);
		res.packet_length = (count_new > sbpd_pkg::CNT_W'(sbpd_pkg::LEN_MAX))
			? sbpd_pkg::LEN_W'(sbpd_pkg::LEN_MAX) : sbpd_pkg::LEN_W'(count_new);
		res.overflow      = ovf_new;
		res_valid         = (kind == sbpd_pkg::KIND_END) || accepted;
	end

	// next state
	always_comb begin
		nxt = cur;
		case (kind)
			sbpd_pkg::KIND_START: begin
				nxt.partial_byte = {rx_byte[5:0], 2'b00};
				nxt.fill_bits    = sbpd_pkg::FILL_START;
				nxt.byte_count   = '0;
				nxt.overflowed   = 1'b0;
			end
			sbpd_pkg::KIND_END: begin
				nxt.partial_byte = 8'h00;
				nxt.fill_bits    = sbpd_pkg::FILL_ALIGNED;
				nxt.byte_count   = '0;
				nxt.overflowed   = 1'b0;
			end
			sbpd_pkg::KIND_DATA: begin
				if (fill_eff == sbpd_pkg::FILL_ALIGNED) begin
					nxt.partial_byte = {rx_byte[6:0], 1'b0};
					nxt.fill_bits    = sbpd_pkg::FILL_DATA;
				end else begin
					nxt.partial_byte = data_shift[7:0];
					nxt.fill_bits    = (fill_eff == 4'd1) ? sbpd_pkg::FILL_ALIGNED
						: fill_eff - 4'd1;
					nxt.byte_count   = count_new;
					nxt.overflowed   = ovf_new;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
